// ===== design/html_entity_escape_defines.svh =====
// ---------------------------------------------------------------------------
// html_entity_escape_defines
// Assertion macros shared by the checker of the HTML escaper.
// ---------------------------------------------------------------------------
`ifndef HTML_ENTITY_ESCAPE_DEFINES_SVH
`define HTML_ENTITY_ESCAPE_DEFINES_SVH

// property checked only while out of reset
`define HEE_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("html_entity_escape check failed");

// property checked at every edge, reset included
`define HEE_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("html_entity_escape reset check failed");

`endif

// ===== design/hee_pkg.sv =====
// ---------------------------------------------------------------------------
// hee_pkg
// Types, constants and entity lookup tables for the HTML escaper.
// ---------------------------------------------------------------------------
`default_nettype none

package hee_pkg;

    // queue between classifier and expander
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // index into an entity, longest is six bytes
    localparam int IDX_W = 3;

    // special input bytes
    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_QUOT = 8'h22;
    localparam logic [7:0] CH_APOS = 8'h27;

    // class of one input byte
    typedef enum logic [2:0] {
        KIND_PLAIN,
        KIND_LT,
        KIND_GT,
        KIND_AMP,
        KIND_QUOT,
        KIND_APOS
    } t_kind;

    // one classified request in the queue
    typedef struct packed {
        t_kind      kind;
        logic [7:0] raw;
        logic       eos;
    } t_entry;

    // queue head as seen by the expander
    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_head;

    // byte classification
    function automatic t_kind classify(input logic [7:0] ch);
        t_kind k;
        case (ch)
            CH_LT:   k = KIND_LT;
            CH_GT:   k = KIND_GT;
            CH_AMP:  k = KIND_AMP;
            CH_QUOT: k = KIND_QUOT;
            CH_APOS: k = KIND_APOS;
            default: k = KIND_PLAIN;
        endcase
        return k;
    endfunction

    // number of output bytes for a class
    function automatic logic [IDX_W-1:0] ent_len(input t_kind kind);
        logic [IDX_W-1:0] n;
        case (kind)
            KIND_LT:   n = IDX_W'(4);
            KIND_GT:   n = IDX_W'(4);
            KIND_AMP:  n = IDX_W'(5);
            KIND_QUOT: n = IDX_W'(6);
            KIND_APOS: n = IDX_W'(5);
            default:   n = IDX_W'(1);
        endcase
        return n;
    endfunction

    // output byte at position idx of the expansion
    function automatic logic [7:0] ent_char(input t_kind kind,
                                            input logic [IDX_W-1:0] idx,
                                            input logic [7:0] raw);
        logic [7:0] c;
        c = 8'h3B; // ';' closes every entity
        if (idx == '0) begin
            c = (kind == KIND_PLAIN) ? raw : CH_AMP;
        end else begin
            case (kind)
                KIND_LT: begin
                    case (idx)
                        IDX_W'(1): c = 8'h6C; // l
                        IDX_W'(2): c = 8'h74; // t
                        default:   c = 8'h3B;
                    endcase
                end
                KIND_GT: begin
                    case (idx)
                        IDX_W'(1): c = 8'h67; // g
                        IDX_W'(2): c = 8'h74; // t
                        default:   c = 8'h3B;
                    endcase
                end
                KIND_AMP: begin
                    case (idx)
                        IDX_W'(1): c = 8'h61; // a
                        IDX_W'(2): c = 8'h6D; // m
                        IDX_W'(3): c = 8'h70; // p
                        default:   c = 8'h3B;
                    endcase
                end
                KIND_QUOT: begin
                    case (idx)
                        IDX_W'(1): c = 8'h71; // q
                        IDX_W'(2): c = 8'h75; // u
                        IDX_W'(3): c = 8'h6F; // o
                        IDX_W'(4): c = 8'h74; // t
                        default:   c = 8'h3B;
                    endcase
                end
                KIND_APOS: begin
                    case (idx)
                        IDX_W'(1): c = 8'h23; // #
                        IDX_W'(2): c = 8'h33; // 3
                        IDX_W'(3): c = 8'h39; // 9
                        default:   c = 8'h3B;
                    endcase
                end
                default: c = raw;
            endcase
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== design/hee_front.sv =====
// ---------------------------------------------------------------------------
// hee_front
// Input side: takes requests from the push port and tags each byte with
// its escape class before it goes into the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module hee_front (
    input  wire logic          push,
    output logic               full,
    input  wire logic [7:0]    i_in_char,
    input  wire logic          i_end_of_string,
    input  wire logic          i_q_full,
    output logic               o_q_wr,
    output hee_pkg::t_entry    o_q_entry
);
    import hee_pkg::*;

    // handshake toward the upstream side
    assign full   = i_q_full;
    assign o_q_wr = push & ~i_q_full;

    // classify the byte
    always_comb begin
        o_q_entry.kind = classify(i_in_char);
        o_q_entry.raw  = i_in_char;
        o_q_entry.eos  = i_end_of_string;
    end

endmodule

`default_nettype wire

// ===== design/hee_queue.sv =====
// ---------------------------------------------------------------------------
// hee_queue
// Short request queue between classifier and expander so that either side
// can stall without holding up the other.
// ---------------------------------------------------------------------------
`default_nettype none

module hee_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_wr,
    input  wire hee_pkg::t_entry i_entry,
    output logic               o_full,
    output hee_pkg::t_head     o_head,
    input  wire logic          i_rd
);
    import hee_pkg::*;

    t_entry           r_mem [Q_DEPTH];
    logic [Q_AW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [Q_AW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [Q_CW-1:0]  r_count, n_count;
    logic             rd_ok;

    // status
    assign o_full       = (r_count == Q_CW'(Q_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.entry = r_mem[r_rd_ptr];
    assign rd_ok        = i_rd & o_head.valid;

    // pointer and count update
    always_comb begin
        n_wr_ptr = i_wr  ? Q_AW'(r_wr_ptr + 1'b1) : r_wr_ptr;
        n_rd_ptr = rd_ok ? Q_AW'(r_rd_ptr + 1'b1) : r_rd_ptr;
        n_count  = r_count;
        if (i_wr && !rd_ok) begin
            n_count = Q_CW'(r_count + 1'b1);
        end else if (!i_wr && rd_ok) begin
            n_count = Q_CW'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

`default_nettype wire

// ===== design/hee_back.sv =====
// ---------------------------------------------------------------------------
// hee_back
// Output side: walks each queued request through its expansion into an
// output register that the pop port drains, one byte per cycle unless a held byte is not popped.
// ---------------------------------------------------------------------------
`default_nettype none

module hee_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire hee_pkg::t_head i_head,
    output logic               o_q_rd,
    output logic               empty,
    input  wire logic          pop,
    output logic [7:0]         o_out_char,
    output logic               o_run_last,
    output logic               o_string_last
);
    import hee_pkg::*;

    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_valid, n_valid;
    logic [7:0]       r_char;
    logic             r_run_last;
    logic             r_str_last;
    logic             load;
    logic             last;
    logic [7:0]       next_char;

    // current byte of the head request
    assign last      = (r_idx == IDX_W'(ent_len(i_head.entry.kind) - 1'b1));
    assign next_char = ent_char(i_head.entry.kind, r_idx, i_head.entry.raw);

    // output register free or being drained this cycle
    assign load   = i_head.valid & (~r_valid | pop);
    assign o_q_rd = load & last;

    // control next state
    always_comb begin
        n_idx   = r_idx;
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
            n_idx   = last ? '0 : IDX_W'(r_idx + 1'b1);
        end else if (pop) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_char     <= next_char;
            r_run_last <= last;
            r_str_last <= last & i_head.entry.eos;
        end
    end

    assign empty         = ~r_valid;
    assign o_out_char    = r_char;
    assign o_run_last    = r_run_last;
    assign o_string_last = r_str_last;

endmodule

`default_nettype wire

// ===== design/html_entity_escape.sv =====
// ---------------------------------------------------------------------------
// html_entity_escape
// Streaming HTML escaper, one text byte in, one escaped byte out per cycle unless stalled.
// ---------------------------------------------------------------------------
// Each pushed byte leaves as one result, except '<', '>', '&', the double
// quote and the apostrophe, which leave as "&lt;", "&gt;", "&amp;", "&quot;"
// and "&#39;" (four to six results). The expander emits one output byte per
// cycle while the output is drained, so plain text flows at one byte per
// cycle and an entity byte holds the output side until all its characters
// are out; a four-entry request queue keeps accepting input meanwhile, and
// full rises only when it fills. A result is written into the request queue
// and then into the output register before it shows on the output. run_last
// marks the final byte of each input byte's expansion and string_last marks
// it when that input carried end_of_string.
// ---------------------------------------------------------------------------
`default_nettype none

module html_entity_escape (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] i_in_char,
    input  wire logic       i_end_of_string,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      o_out_char,
    output logic            o_run_last,
    output logic            o_string_last
);
    import hee_pkg::*;

    logic   q_wr;
    logic   q_full;
    logic   q_rd;
    t_entry q_entry;
    t_head  q_head;

    // classifier
    hee_front u_front (
        .push            (push),
        .full            (full),
        .i_in_char       (i_in_char),
        .i_end_of_string (i_end_of_string),
        .i_q_full        (q_full),
        .o_q_wr          (q_wr),
        .o_q_entry       (q_entry)
    );

    // request queue
    hee_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_entry (q_entry),
        .o_full  (q_full),
        .o_head  (q_head),
        .i_rd    (q_rd)
    );

    // expander
    hee_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (q_head),
        .o_q_rd        (q_rd),
        .empty         (empty),
        .pop           (pop),
        .o_out_char    (o_out_char),
        .o_run_last    (o_run_last),
        .o_string_last (o_string_last)
    );

endmodule

`default_nettype wire

// ===== design/hee_checker.sv =====
// ---------------------------------------------------------------------------
// hee_checker
// Port-level checks of the HTML escaper, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "html_entity_escape_defines.svh"

module hee_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       full,
    input wire logic       empty,
    input wire logic       pop,
    input wire logic [7:0] o_out_char,
    input wire logic       o_run_last,
    input wire logic       o_string_last
);

    // nothing waits on the output right after reset
    `HEE_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> empty)

    // the request queue starts out with room
    `HEE_ASSERT_ALWAYS(a_reset_not_full, !i_rst_n |=> !full)

    // a waiting result is held until it is taken
    `HEE_ASSERT(a_hold, (!empty && !pop) |=> (!empty && $stable(o_out_char)))

    // end of string only closes a run
    `HEE_ASSERT(a_str_in_run, (!empty && o_string_last) |-> o_run_last)

    // an ampersand in the output always opens an entity
    `HEE_ASSERT(a_amp_opens, (!empty && o_out_char == 8'h26) |-> !o_run_last)

endmodule

bind html_entity_escape hee_checker u_checker (.*);

`default_nettype wire

// ===== bench/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the streaming HTML escaper.
// ---------------------------------------------------------------------------
// A driver pushes text bytes from a pending queue and a monitor pops escaped
// bytes. Every accepted request is expanded here into the bytes the escaper
// should emit, and each popped byte is compared with the oldest of them.
// Both sides idle at random, each with one calm stretch, and one long output stall
// that fills the request queue and backs up the input.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import hee_pkg::*;

    // one text byte with its end-of-string flag
    typedef struct packed {
        logic [7:0] ch;
        logic       eos;
    } t_text_byte;

    // one escaped output byte as it should appear
    typedef struct packed {
        logic [7:0] ch;
        logic       run_last;
        logic       string_last;
    } t_escaped_byte;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 80;
    localparam int RANDOM_ITEMS = 300;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic [7:0] i_in_char = 8'h00;
    logic       i_end_of_string = 1'b0;
    logic       pop = 1'b0;
    logic       full;
    logic       empty;
    logic [7:0] o_out_char;
    logic       o_run_last;
    logic       o_string_last;

    t_text_byte    text_q[$];
    t_escaped_byte escaped_q[$];

    int total_bytes = 0;
    int bytes_accepted = 0;
    int results_seen = 0;
    int mismatch_count = 0;
    int stall_cycles = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    html_entity_escape i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_in_char      (i_in_char),
        .i_end_of_string(i_end_of_string),
        .empty          (empty),
        .pop            (pop),
        .o_out_char     (o_out_char),
        .o_run_last     (o_run_last),
        .o_string_last  (o_string_last)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // mismatch reporting
    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // expand one text byte into the escaped bytes it should produce
    function automatic void escape_byte(input logic [7:0] ch, input logic eos);
        string         ent;
        t_escaped_byte eb;
        ent = "";
        case (ch)
            CH_LT:   ent = "&lt;";
            CH_GT:   ent = "&gt;";
            CH_AMP:  ent = "&amp;";
            CH_QUOT: ent = "&quot;";
            CH_APOS: ent = "&#39;";
            default: ent = "";
        endcase
        if (ent.len() == 0) begin
            eb.ch = ch;
            eb.run_last = 1'b1;
            eb.string_last = eos;
            escaped_q.push_back(eb);
        end else begin
            for (int k = 0; k < ent.len(); k++) begin
                eb.ch = ent[k];
                eb.run_last = (k == ent.len() - 1);
                eb.string_last = (k == ent.len() - 1) && eos;
                escaped_q.push_back(eb);
            end
        end
    endfunction

    // queue one text byte for the driver
    task automatic add_byte(input logic [7:0] ch, input logic eos);
        t_text_byte tb_item;
        tb_item.ch = ch;
        tb_item.eos = eos;
        text_q.push_back(tb_item);
    endtask

    // pick a byte, biased toward the ones that expand
    function automatic logic [7:0] pick_char();
        logic [7:0] c;
        if ($urandom_range(0, 99) < 40) begin
            case ($urandom_range(0, 4))
                0:       c = CH_LT;
                1:       c = CH_GT;
                2:       c = CH_AMP;
                3:       c = CH_QUOT;
                default: c = CH_APOS;
            endcase
        end else begin
            c = 8'($urandom_range(0, 255));
        end
        return c;
    endfunction

    // driver: offers pending requests, holds them while full
    always @(posedge i_clk) begin
        bit calm;
        t_text_byte nxt;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (!(push && full)) begin
            if (push) begin
                escape_byte(i_in_char, i_end_of_string);
                bytes_accepted++;
            end
            calm = (bytes_accepted >= 100 && bytes_accepted < 180);
            if (text_q.size() != 0 && (calm || $urandom_range(0, 99) >= 24)) begin
                nxt = text_q.pop_front();
                push <= 1'b1;
                i_in_char <= nxt.ch;
                i_end_of_string <= nxt.eos;
            end else begin
                push <= 1'b0;
            end
        end
    end

    // monitor: pops results and checks them against the expansion
    always @(posedge i_clk) begin
        bit calm;
        t_escaped_byte want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                results_seen++;
                if (escaped_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected byte %h", o_out_char));
                end else begin
                    want = escaped_q.pop_front();
                    if (o_out_char !== want.ch)
                        report_mismatch($sformatf("out_char %h, wanted %h",
                                                  o_out_char, want.ch));
                    if (o_run_last !== want.run_last)
                        report_mismatch($sformatf("run_last %b, wanted %b on %h",
                                                  o_run_last, want.run_last, want.ch));
                    if (o_string_last !== want.string_last)
                        report_mismatch($sformatf("string_last %b, wanted %b on %h",
                                                  o_string_last, want.string_last,
                                                  want.ch));
                end
            end
            // one long output stall to back up the input side
            if (!hold_done && results_seen >= 60) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            calm = (results_seen >= 200 && results_seen < 320);
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= calm || ($urandom_range(0, 99) >= 24);
            end
        end
    end

    // watchdog on cycles without any request or result moving
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((push && !full) || (pop && !empty)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // stimulus and end of run
    initial begin
        int len;
        // directed: field extremes, every entity, end flag both ways
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b1);
        add_byte(CH_LT, 1'b0);
        add_byte(CH_GT, 1'b0);
        add_byte(CH_AMP, 1'b0);
        add_byte(CH_QUOT, 1'b0);
        add_byte(CH_APOS, 1'b1);
        add_byte(CH_LT, 1'b1);
        add_byte(CH_GT, 1'b1);
        add_byte(CH_AMP, 1'b1);
        add_byte(CH_QUOT, 1'b1);
        // zero byte in the middle and at the end of a string
        add_byte(8'h41, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h00, 1'b1);
        // single-byte strings
        add_byte(8'h80, 1'b1);
        add_byte(8'h7F, 1'b1);
        // neighbors of the special bytes pass through
        add_byte(8'h3B, 1'b0);
        add_byte(8'h3D, 1'b0);
        add_byte(8'h3F, 1'b0);
        add_byte(8'h21, 1'b0);
        add_byte(8'h23, 1'b0);
        add_byte(8'h25, 1'b0);
        add_byte(8'h28, 1'b0);
        add_byte(8'h01, 1'b1);
        // random strings with random content
        while (text_q.size() < RANDOM_ITEMS + 24) begin
            len = $urandom_range(1, 12);
            for (int k = 0; k < len; k++)
                add_byte(pick_char(), (k == len - 1));
        end
        total_bytes = text_q.size();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (bytes_accepted < total_bytes) @(posedge i_clk);
        while (escaped_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
